/* hdl/tlv_pkg.sv */
// Shared types, codes and the CRC-16/CCITT-FALSE byte step for the TLV image decoder.
// No dependencies; imported by tlv_image_decoder.
package tlv_pkg;

  // Default saturation point of the image byte counter
  localparam int COUNT_LIMIT_DEF = 4096;
  // Fixed header size in bytes
  localparam int HDR_SIZE = 6;
  // Result queue depth
  localparam int QDEPTH = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  BLANK_BYTE = 8'hFF;

  // Result kind, carried on tuser
  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Final status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BLANK       = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_MAGIC   = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_BAD_CRC     = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAGIC_FIRST    = 3'd0,
    CFG_MAGIC_SECOND   = 3'd1,
    CFG_FORMAT_VERSION = 3'd2,
    CFG_END_TAG        = 3'd3,
    CFG_PAYLOAD_LIMIT  = 3'd4,
    CFG_IMAGE_LENGTH   = 3'd5
  } cfg_idx_t;

  // Record parser phase, one-hot
  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_VAL  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [7:0]  record_tag;
    logic [7:0]  record_length;
    logic [7:0]  byte_index;
    logic [7:0]  value_byte;
    logic        run_end;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/tlv_image_decoder.sv */
// TLV settings image decoder: header check, CRC-16/CCITT-FALSE, record split.
// Depends on tlv_pkg (types, codes, CRC step).
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata image byte, in_tlast final byte
//  out_    | out | out_tvalid/out_tready| out_tdata record fields, out_tuser kind,
//          |     |                      | out_tlast run end (final status)
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One image byte per cycle while the queue has room: the header/CRC/parser step is
// combinational logic from the state registers into a 4-entry result queue, and
// results are pushed at the byte transfer. The unrolled 8-bit CRC step sets the path length.
// A byte is taken while the queue has two free entries, so a stalled consumer
// throttles the input only after results back up. Synchronous active-low reset
// clears the run state, the queue and loads the register defaults.
module tlv_image_decoder #(
  parameter int COUNT_LIMIT = tlv_pkg::COUNT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] image_byte
  input  logic        in_tlast,    // final_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [2:0] status, [10:3] record_tag, [18:11] record_length,
                                   // [26:19] byte_index, [34:27] value_byte, [39:35] zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast,   // run_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import tlv_pkg::*;

  localparam int CW = $clog2(COUNT_LIMIT + 1);
  localparam int LW = (CW > 13) ? CW : 13;
  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  // configuration registers
  logic [7:0]  magic_first_r, magic_second_r, format_version_r, end_tag_r, payload_limit_r;
  logic [12:0] image_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r    <= '0;
      magic_second_r   <= '0;
      format_version_r <= '0;
      end_tag_r        <= '0;
      payload_limit_r  <= 8'hFF;
      image_length_r   <= 13'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC_FIRST:    magic_first_r    <= cfg_data[7:0];
        CFG_MAGIC_SECOND:   magic_second_r   <= cfg_data[7:0];
        CFG_FORMAT_VERSION: format_version_r <= cfg_data[7:0];
        CFG_END_TAG:        end_tag_r        <= cfg_data[7:0];
        CFG_PAYLOAD_LIMIT:  payload_limit_r  <= cfg_data[7:0];
        CFG_IMAGE_LENGTH:   image_length_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // run state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [15:0]   scrc_r, scrc_nxt;
  logic [7:0]    first_r, first_nxt;
  status_t       hst_r, hst_nxt;
  logic [7:0]    psize_r, psize_nxt;
  logic [8:0]    off_r, off_nxt;
  phase_t        ph_r, ph_nxt;
  logic [7:0]    tag_r, tag_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    vpos_r, vpos_nxt;
  logic          trunc_r, trunc_nxt;

  logic          in_xfer;
  logic          rec_v;
  result_t       rec_res, st_res;
  status_t       fin_st;
  logic [15:0]   crc_step;
  logic [9:0]    len_end;
  logic [8:0]    tag_end;
  logic [8:0]    hdr_plus;

  assign in_xfer  = in_tvalid && in_tready;
  assign crc_step = crc_byte(crc_r, in_tdata);
  assign tag_end  = off_r + 9'd2;
  assign len_end  = {1'b0, off_r} + 10'd1 + {2'b00, in_tdata};

  // per-byte header, CRC and record parser step
  always_comb begin
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    scrc_nxt  = scrc_r;
    first_nxt = first_r;
    hst_nxt   = hst_r;
    psize_nxt = psize_r;
    off_nxt   = off_r;
    ph_nxt    = ph_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    vpos_nxt  = vpos_r;
    trunc_nxt = trunc_r;
    rec_v     = 1'b0;
    rec_res   = '0;

    if (cnt_r == CW'(0)) begin
      first_nxt = in_tdata;
    end else if (cnt_r == CW'(1)) begin
      if (first_r == BLANK_BYTE && in_tdata == BLANK_BYTE) begin
        hst_nxt = ST_BLANK;
      end else if (first_r != magic_first_r || in_tdata != magic_second_r) begin
        hst_nxt = ST_BAD_MAGIC;
      end
    end else if (cnt_r == CW'(2)) begin
      scrc_nxt = {in_tdata, 8'h00};
    end else if (cnt_r == CW'(3)) begin
      scrc_nxt = {scrc_r[15:8], in_tdata};
    end else if (cnt_r == CW'(4)) begin
      crc_nxt = crc_step;
      if (hst_r == ST_OK && in_tdata != format_version_r) hst_nxt = ST_BAD_VERSION;
    end else if (cnt_r == CW'(5)) begin
      crc_nxt   = crc_step;
      psize_nxt = in_tdata;
      if (hst_r == ST_OK && in_tdata > payload_limit_r) hst_nxt = ST_BAD_LENGTH;
    end else if (off_r < {1'b0, psize_r}) begin
      crc_nxt = crc_step;
      off_nxt = off_r + 9'd1;
      unique case (ph_r)
        PH_TAG: begin
          if (in_tdata == end_tag_r) begin
            ph_nxt = PH_DONE;
          end else if (tag_end > {1'b0, psize_r}) begin
            trunc_nxt = 1'b1;
            ph_nxt    = PH_DONE;
          end else begin
            tag_nxt = in_tdata;
            ph_nxt  = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt = in_tdata;
          if (len_end > {2'b00, psize_r}) begin
            trunc_nxt = 1'b1;
            ph_nxt    = PH_DONE;
          end else if (in_tdata == 8'd0) begin
            rec_v              = 1'b1;
            rec_res.kind       = KIND_EMPTY;
            rec_res.record_tag = tag_r;
            ph_nxt             = PH_TAG;
          end else begin
            vpos_nxt = '0;
            ph_nxt   = PH_VAL;
          end
        end
        PH_VAL: begin
          rec_v                 = 1'b1;
          rec_res.kind          = KIND_VALUE;
          rec_res.record_tag    = tag_r;
          rec_res.record_length = len_r;
          rec_res.byte_index    = vpos_r;
          rec_res.value_byte    = in_tdata;
          vpos_nxt              = vpos_r + 8'd1;
          if (vpos_nxt >= len_r) ph_nxt = PH_TAG;
        end
        PH_DONE: ;
        default: ;
      endcase
    end

    if (cnt_r < CW'(COUNT_LIMIT)) cnt_nxt = cnt_r + CW'(1);
  end

  // final status from the updated state
  assign hdr_plus = 9'(HDR_SIZE) + {1'b0, psize_nxt};

  always_comb begin
    if (LW'(cnt_nxt) < LW'(image_length_r) || LW'(cnt_nxt) < LW'(hdr_plus)) begin
      fin_st = ST_BAD_LENGTH;
    end else if (hst_nxt != ST_OK) begin
      fin_st = hst_nxt;
    end else if (crc_nxt != scrc_nxt) begin
      fin_st = ST_BAD_CRC;
    end else if (trunc_nxt) begin
      fin_st = ST_TRUNCATED;
    end else begin
      fin_st = ST_OK;
    end
    st_res         = '0;
    st_res.kind    = KIND_STATUS;
    st_res.status  = fin_st;
    st_res.run_end = 1'b1;
  end

  // state registers; a final byte returns the run to its start
  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_tlast)) begin
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
      scrc_r  <= '0;
      first_r <= '0;
      hst_r   <= ST_OK;
      psize_r <= '0;
      off_r   <= '0;
      ph_r    <= PH_TAG;
      tag_r   <= '0;
      len_r   <= '0;
      vpos_r  <= '0;
      trunc_r <= 1'b0;
    end else if (in_xfer) begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      scrc_r  <= scrc_nxt;
      first_r <= first_nxt;
      hst_r   <= hst_nxt;
      psize_r <= psize_nxt;
      off_r   <= off_nxt;
      ph_r    <= ph_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      vpos_r  <= vpos_nxt;
      trunc_r <= trunc_nxt;
    end
  end

  // result queue: up to two pushes per byte, one pop per cycle
  result_t         q_mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   fill_r, fill_nxt;
  logic            push_a, push_b, pop;
  result_t         ent_a;
  logic [1:0]      n_push;

  assign in_tready = (fill_r <= NW'(QDEPTH - 2));
  assign pop       = out_tvalid && out_tready;
  assign push_a    = in_xfer && (rec_v || in_tlast);
  assign push_b    = in_xfer && rec_v && in_tlast;
  assign ent_a     = rec_v ? rec_res : st_res;
  assign n_push    = {1'b0, push_a} + {1'b0, push_b};
  assign fill_nxt  = fill_r + NW'(n_push) - NW'(pop);

  always_ff @(posedge clk) begin
    if (push_a) q_mem[wr_ptr_r] <= ent_a;
    if (push_b) q_mem[wr_ptr_r + PW'(1)] <= st_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(n_push);
      if (pop) rd_ptr_r <= rd_ptr_r + PW'(1);
      fill_r <= fill_nxt;
    end
  end

  // output packing
  result_t head;
  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (fill_r != '0);
  assign out_tdata  = {5'b0, head.value_byte, head.byte_index, head.record_length,
                       head.record_tag, head.status};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_end;

endmodule

/* test/tlv_image_decoder_tb.sv */
// Testbench for tlv_image_decoder: streams settings images, predicts every record and
// status transfer in a local decoder model, checks the result stream field by field.
// Depends on tlv_pkg and tlv_image_decoder.
`timescale 1ns / 100ps

module tlv_image_decoder_tb;
  import tlv_pkg::*;

  localparam int COUNT_SAT = COUNT_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 650;

  typedef enum {BODY_RECORDS, BODY_END_TAG, BODY_OVERRUN, BODY_NOISE} body_t;
  typedef enum {FAULT_NONE, FAULT_MAGIC, FAULT_BLANK, FAULT_VERSION, FAULT_CRC} fault_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } image_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  tlv_image_decoder #(.COUNT_LIMIT(COUNT_SAT)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Model copy of the configuration registers
  logic [7:0]  magic_first_reg, magic_second_reg, version_reg, end_tag_reg;
  logic [7:0]  payload_limit_reg;
  logic [12:0] image_length_reg;

  // Model copy of the per-image decode state
  logic [12:0] seen_count;
  logic [15:0] crc_acc, header_crc;
  logic [7:0]  lead_byte;
  status_t     hdr_status;
  logic [7:0]  payload_len;
  logic [8:0]  payload_pos;
  phase_t      rec_phase;
  logic [7:0]  rec_tag, rec_len, rec_pos;
  logic        rec_truncated;

  result_t     expected_results[$];
  image_beat_t byte_feed[$];
  logic [7:0]  payload_buf[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          feed_gap = 0;
  int          drain_stall = 0;
  bit          quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** tlv_image_decoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- decoder model

  // CRC-16/CCITT-FALSE, one input bit per iteration
  function automatic logic [15:0] crc16_ccitt(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void add_result(input kind_t k, input status_t st, input logic [7:0] tag,
                                     input logic [7:0] len, input logic [7:0] idx,
                                     input logic [7:0] val, input logic fin);
    result_t r;
    r.kind = k;
    r.status = st;
    r.record_tag = tag;
    r.record_length = len;
    r.byte_index = idx;
    r.value_byte = val;
    r.run_end = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_run_state();
    seen_count = '0;
    crc_acc = CRC_INIT;
    header_crc = '0;
    lead_byte = '0;
    hdr_status = ST_OK;
    payload_len = '0;
    payload_pos = '0;
    rec_phase = PH_TAG;
    rec_tag = '0;
    rec_len = '0;
    rec_pos = '0;
    rec_truncated = 1'b0;
  endfunction

  // One image byte in; record results and, on the last byte, the final status out
  function automatic void decode_image_byte(input logic [7:0] b, input logic last);
    status_t st;
    case (seen_count)
      13'd0: lead_byte = b;
      13'd1: begin
        if (lead_byte == BLANK_BYTE && b == BLANK_BYTE) hdr_status = ST_BLANK;
        else if (lead_byte != magic_first_reg || b != magic_second_reg)
          hdr_status = ST_BAD_MAGIC;
      end
      13'd2: header_crc[15:8] = b;
      13'd3: header_crc[7:0] = b;
      13'd4: begin
        crc_acc = crc16_ccitt(crc_acc, b);
        if (hdr_status == ST_OK && b != version_reg) hdr_status = ST_BAD_VERSION;
      end
      13'd5: begin
        crc_acc = crc16_ccitt(crc_acc, b);
        payload_len = b;
        if (hdr_status == ST_OK && b > payload_limit_reg) hdr_status = ST_BAD_LENGTH;
      end
      default: begin
        if (payload_pos < payload_len) begin
          crc_acc = crc16_ccitt(crc_acc, b);
          case (rec_phase)
            PH_TAG: begin
              if (b == end_tag_reg) begin
                rec_phase = PH_DONE;
              end else if (payload_pos + 2 > payload_len) begin
                // tag with no room left for its length byte
                rec_truncated = 1'b1;
                rec_phase = PH_DONE;
              end else begin
                rec_tag = b;
                rec_phase = PH_LEN;
              end
            end
            PH_LEN: begin
              rec_len = b;
              if (payload_pos + 1 + b > payload_len) begin
                rec_truncated = 1'b1;
                rec_phase = PH_DONE;
              end else if (b == 8'd0) begin
                add_result(KIND_EMPTY, ST_OK, rec_tag, 8'd0, 8'd0, 8'd0, 1'b0);
                rec_phase = PH_TAG;
              end else begin
                rec_pos = 8'd0;
                rec_phase = PH_VAL;
              end
            end
            PH_VAL: begin
              add_result(KIND_VALUE, ST_OK, rec_tag, rec_len, rec_pos, b, 1'b0);
              rec_pos++;
              if (rec_pos >= rec_len) rec_phase = PH_TAG;
            end
            default: ;
          endcase
          payload_pos++;
        end
      end
    endcase

    if (seen_count < COUNT_SAT) seen_count++;

    if (last) begin
      if (seen_count < image_length_reg || seen_count < HDR_SIZE + payload_len)
        st = ST_BAD_LENGTH;
      else if (hdr_status != ST_OK) st = hdr_status;
      else if (crc_acc != header_crc) st = ST_BAD_CRC;
      else if (rec_truncated) st = ST_TRUNCATED;
      else st = ST_OK;
      add_result(KIND_STATUS, st, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      clear_run_state();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Short gaps mostly, now and then a long one; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Image byte feed; the model sees each byte at its transfer
  always @(posedge clk) begin : feed
    image_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_image_byte(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_tvalid <= 1'b0;
        end else if (byte_feed.size() != 0) begin
          beat = byte_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= beat.data;
          in_tlast <= beat.last;
          feed_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor with random back-pressure
  always @(posedge clk) begin : drain
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      drain_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with none expected: kind %0d, tdata %h", out_tuser, out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("status", want.status, out_tdata[2:0]);
          check_field("record_tag", want.record_tag, out_tdata[10:3]);
          check_field("record_length", want.record_length, out_tdata[18:11]);
          check_field("byte_index", want.byte_index, out_tdata[26:19]);
          check_field("value_byte", want.value_byte, out_tdata[34:27]);
          check_field("run_end", want.run_end, out_tlast);
        end
      end
      if (drain_stall > 0) begin
        drain_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) drain_stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_register(input cfg_idx_t idx, input logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAGIC_FIRST:    magic_first_reg = value[7:0];
      CFG_MAGIC_SECOND:   magic_second_reg = value[7:0];
      CFG_FORMAT_VERSION: version_reg = value[7:0];
      CFG_END_TAG:        end_tag_reg = value[7:0];
      CFG_PAYLOAD_LIMIT:  payload_limit_reg = value[7:0];
      CFG_IMAGE_LENGTH:   image_length_reg = value;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [7:0] m0, input logic [7:0] m1,
                                input logic [7:0] ver, input logic [7:0] etag,
                                input logic [7:0] limit, input logic [12:0] ilen);
    write_register(CFG_MAGIC_FIRST, m0);
    write_register(CFG_MAGIC_SECOND, m1);
    write_register(CFG_FORMAT_VERSION, ver);
    write_register(CFG_END_TAG, etag);
    write_register(CFG_PAYLOAD_LIMIT, limit);
    write_register(CFG_IMAGE_LENGTH, ilen);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int r;
    logic [7:0] limit;
    r = $urandom_range(0, 5);
    limit = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
    write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), limit,
                   ($urandom_range(0, 3) == 0) ? 13'd6 : 13'($urandom_range(6, 48)));
  endtask

  // Idle: every byte taken, every result seen, then a short drain
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] random_tag();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == end_tag_reg);
    return v;
  endfunction

  // Value bytes sometimes mimic the end tag; it must not stop parsing there
  function automatic logic [7:0] random_value();
    return ($urandom_range(0, 7) == 0) ? end_tag_reg : 8'($urandom_range(0, 255));
  endfunction

  task automatic fill_payload(input int plen, input body_t body);
    int room, len, cap;
    payload_buf.delete();
    room = plen;
    if (body == BODY_NOISE) begin
      repeat (plen) payload_buf.push_back(8'($urandom_range(0, 255)));
      room = 0;
    end
    while (room > 0) begin
      if (room == 1) begin
        // a lone tag byte at the payload end overruns unless it is the end tag
        payload_buf.push_back(body == BODY_OVERRUN ? random_tag() : end_tag_reg);
        room = 0;
      end else if ((body == BODY_END_TAG && $urandom_range(0, 3) == 0) ||
                   (body == BODY_OVERRUN && $urandom_range(0, 2) == 0)) begin
        if (body == BODY_END_TAG) begin
          payload_buf.push_back(end_tag_reg);
        end else begin
          payload_buf.push_back(random_tag());
          payload_buf.push_back(8'($urandom_range(room - 1, 255)));
        end
        while (payload_buf.size() < plen) payload_buf.push_back(random_value());
        room = 0;
      end else begin
        cap = ($urandom_range(0, 7) == 0 || room < 14) ? room - 2 : 12;
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, cap);
        payload_buf.push_back(random_tag());
        payload_buf.push_back(8'(len));
        repeat (len) payload_buf.push_back(random_value());
        room -= len + 2;
      end
    end
  endtask

  // Header + payload_buf + trailing bytes; cut >= 0 ends the image early at that byte
  task automatic queue_image(input fault_t fault, input bit pad, input int trail,
                             input int cut);
    logic [7:0]  img[$];
    logic [15:0] crc;
    image_beat_t beat;
    int k, total, spot;
    img = '{magic_first_reg, magic_second_reg, 8'h00, 8'h00, version_reg,
            8'(payload_buf.size())};
    spot = $urandom_range(0, 1);
    case (fault)
      FAULT_MAGIC:   img[spot] = img[spot] ^ 8'(1 << $urandom_range(0, 7));
      FAULT_BLANK:   begin img[0] = BLANK_BYTE; img[1] = BLANK_BYTE; end
      FAULT_VERSION: img[4] = img[4] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    foreach (payload_buf[i]) img.push_back(payload_buf[i]);
    crc = CRC_INIT;
    for (k = 4; k < img.size(); k++) crc = crc16_ccitt(crc, img[k]);
    if (fault == FAULT_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    img[2] = crc[15:8];
    img[3] = crc[7:0];
    if (pad && image_length_reg > img.size()) trail += image_length_reg - img.size();
    repeat (trail) img.push_back(8'($urandom_range(0, 255)));
    total = (cut >= 0 && cut < img.size()) ? cut + 1 : img.size();
    for (k = 0; k < total; k++) begin
      beat.data = img[k];
      beat.last = (k == total - 1);
      byte_feed.push_back(beat);
      bytes_queued++;
    end
  endtask

  task automatic queue_random_image();
    int r, plen, top;
    body_t body;
    fault_t fault;
    r = $urandom_range(0, 99);
    top = (payload_limit_reg < 24) ? payload_limit_reg : 24;
    if (r < 55) plen = $urandom_range(0, top);
    else if (r < 85) plen = $urandom_range(0, payload_limit_reg);
    else if (payload_limit_reg < 255) plen = $urandom_range(payload_limit_reg + 1, 255);
    else plen = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    body = (r < 60) ? BODY_RECORDS : (r < 75) ? BODY_END_TAG :
           (r < 90) ? BODY_OVERRUN : BODY_NOISE;
    r = $urandom_range(0, 99);
    fault = (r < 75) ? FAULT_NONE : (r < 82) ? FAULT_MAGIC : (r < 87) ? FAULT_BLANK :
            (r < 93) ? FAULT_VERSION : FAULT_CRC;
    fill_payload(plen, body);
    queue_image(fault, $urandom_range(0, 9) != 0,
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                ($urandom_range(0, 11) == 0) ? $urandom_range(0, plen + 8) : -1);
  endtask

  initial begin
    int random_start;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAGIC_FIRST;
    cfg_data = '0;
    magic_first_reg = 8'h00;
    magic_second_reg = 8'h00;
    version_reg = 8'h00;
    end_tag_reg = 8'h00;
    payload_limit_reg = 8'd255;
    image_length_reg = 13'd256;
    clear_run_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a good but short image fails the minimum image length
    payload_buf = '{8'h01, 8'h00};
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    wait_idle();

    // Directed: last byte also closes an empty record, lone trailing tag,
    // record length past the payload end, one-byte image
    write_settings(8'hA5, 8'h5A, 8'h01, 8'hEE, 8'd255, 13'd6);
    payload_buf = '{8'h02, 8'h02, 8'h00, 8'hFF, 8'h01, 8'h00};
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    payload_buf = '{8'h05};
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    payload_buf = '{8'h05, 8'h09};
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    queue_image(FAULT_NONE, 1'b0, 0, 0);
    wait_idle();

    // Register extremes
    write_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 13'd6);
    repeat (6) queue_random_image();
    wait_idle();
    write_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'd255, 13'd6);
    repeat (6) queue_random_image();
    wait_idle();
    write_settings(8'h3C, 8'hC3, 8'h10, 8'h7F, 8'd200, 13'd4096);
    repeat (2) begin
      fill_payload($urandom_range(0, 12), BODY_RECORDS);
      queue_image(FAULT_NONE, 1'b0, 0, -1);
    end
    wait_idle();
    write_settings(8'h3C, 8'hC3, 8'h10, 8'h7F, 8'd200, 13'd8191);
    fill_payload(8, BODY_RECORDS);
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    wait_idle();

    // Minimum length just past the byte counter range can never be met
    write_settings(8'h3C, 8'hC3, 8'h10, 8'h7F, 8'd255, 13'd4097);
    fill_payload(24, BODY_RECORDS);
    queue_image(FAULT_NONE, 1'b0, 0, -1);
    wait_idle();

    // Random settings, each with a handful of images
    random_start = bytes_queued;
    while (bytes_queued - random_start < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      random_config();
      repeat ($urandom_range(3, 8)) queue_random_image();
      wait_idle();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** tlv_image_decoder: PASSED **");
    end else begin
      $display("** tlv_image_decoder: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tlv_pkg.sv
hdl/tlv_image_decoder.sv
test/tlv_image_decoder_tb.sv
